/* src/mol_pkg.sv */
// Move order list table: shared types, command codes and the fixed square priority table.
// No dependencies; imported by the top level, mol_ctrl and the testbench (mol_ram uses none of it).
package mol_pkg;

  localparam int IDX_W  = 6;
  localparam int SQ_W   = 6;
  localparam int KEEP_W = 7;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd24;
  // same-parity stages are two apart
  localparam logic [5:0]        PARITY_STEP = 6'd2;

  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_INHERIT = 2'd1;
  localparam logic [1:0] MODE_REORDER = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COPY,
    S_SORT,
    S_DRAIN,
    S_READ,
    S_RDATA
  } mol_state_t;

  function automatic logic [SQ_W-1:0] prio_sq(input logic [IDX_W-1:0] idx);
    logic [SQ_W-1:0] sq;
    unique case (idx)
      6'd0:  sq = 6'd0;   6'd1:  sq = 6'd63;  6'd2:  sq = 6'd56;  6'd3:  sq = 6'd7;
      6'd4:  sq = 6'd2;   6'd5:  sq = 6'd5;   6'd6:  sq = 6'd16;  6'd7:  sq = 6'd23;
      6'd8:  sq = 6'd40;  6'd9:  sq = 6'd47;  6'd10: sq = 6'd58;  6'd11: sq = 6'd61;
      6'd12: sq = 6'd18;  6'd13: sq = 6'd21;  6'd14: sq = 6'd42;  6'd15: sq = 6'd45;
      6'd16: sq = 6'd3;   6'd17: sq = 6'd4;   6'd18: sq = 6'd24;  6'd19: sq = 6'd31;
      6'd20: sq = 6'd32;  6'd21: sq = 6'd39;  6'd22: sq = 6'd59;  6'd23: sq = 6'd60;
      6'd24: sq = 6'd19;  6'd25: sq = 6'd20;  6'd26: sq = 6'd26;  6'd27: sq = 6'd29;
      6'd28: sq = 6'd34;  6'd29: sq = 6'd37;  6'd30: sq = 6'd43;  6'd31: sq = 6'd44;
      6'd32: sq = 6'd11;  6'd33: sq = 6'd12;  6'd34: sq = 6'd25;  6'd35: sq = 6'd30;
      6'd36: sq = 6'd33;  6'd37: sq = 6'd38;  6'd38: sq = 6'd51;  6'd39: sq = 6'd52;
      6'd40: sq = 6'd10;  6'd41: sq = 6'd13;  6'd42: sq = 6'd17;  6'd43: sq = 6'd22;
      6'd44: sq = 6'd41;  6'd45: sq = 6'd46;  6'd46: sq = 6'd50;  6'd47: sq = 6'd53;
      6'd48: sq = 6'd1;   6'd49: sq = 6'd6;   6'd50: sq = 6'd8;   6'd51: sq = 6'd15;
      6'd52: sq = 6'd48;  6'd53: sq = 6'd55;  6'd54: sq = 6'd57;  6'd55: sq = 6'd62;
      6'd56: sq = 6'd9;   6'd57: sq = 6'd14;  6'd58: sq = 6'd49;  6'd59: sq = 6'd54;
      6'd60: sq = 6'd27;  6'd61: sq = 6'd28;  6'd62: sq = 6'd35;  6'd63: sq = 6'd36;
      default: sq = 6'd0;
    endcase
    return sq;
  endfunction

endpackage

/* src/move_order_list_table.sv */
// Move order list table top level: list RAM, scratch RAM and command sequencer.
// Depends on mol_pkg, mol_ram and mol_ctrl.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+-----------------------------------------
//  command  | start, busy                | in_mode, in_stage, in_my_discs,
//           |                            | in_opp_discs, in_entry_index
//  result   | out_valid (one-cycle pulse)| out_square_out, out_copied
//  config   | cfg_valid, cfg_ready       | cfg_keep_count
//
// Inherit searches back for a marked stage of the same parity, then copies its list.
// Reorder and copy move one list word at a time through the single read and write port
// of the list RAM.
// The result pulse comes in the first cycle with busy low; a new command may start then.
// Reset clears flags and control; list contents are undefined until an init command.
// The receiver cannot stall; cfg_ready is always high.
module move_order_list_table #(
  parameter int LIST_LEN   = 60,
  parameter int NUM_STAGES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [5:0]                  in_stage,
  input  logic [63:0]                 in_my_discs,
  input  logic [63:0]                 in_opp_discs,
  input  logic [mol_pkg::IDX_W-1:0]   in_entry_index,
  output logic                        out_valid,
  output logic [mol_pkg::SQ_W-1:0]    out_square_out,
  output logic                        out_copied,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mol_pkg::KEEP_W-1:0]  cfg_keep_count
);
  import mol_pkg::*;

  localparam int SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int AW = SW + IDX_W;

  logic              m_we;
  logic [AW-1:0]     m_waddr, m_raddr;
  logic [SQ_W-1:0]   m_wdata, m_rdata;
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr, s_raddr;
  logic [SQ_W-1:0]   s_wdata, s_rdata;

  assign cfg_ready = 1'b1;

  mol_ram #(.AW(AW), .DW(SQ_W)) u_list_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  mol_ram #(.AW(IDX_W), .DW(SQ_W)) u_scratch_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mol_ctrl #(
    .LIST_LEN   (LIST_LEN),
    .NUM_STAGES (NUM_STAGES),
    .SW         (SW),
    .AW         (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_stage       (in_stage),
    .in_my_discs    (in_my_discs),
    .in_opp_discs   (in_opp_discs),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_square_out (out_square_out),
    .out_copied     (out_copied),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_keep_count (cfg_keep_count),
    .m_we           (m_we),
    .m_waddr        (m_waddr),
    .m_wdata        (m_wdata),
    .m_raddr        (m_raddr),
    .m_rdata        (m_rdata),
    .s_we           (s_we),
    .s_waddr        (s_waddr),
    .s_wdata        (s_wdata),
    .s_raddr        (s_raddr),
    .s_rdata        (s_rdata)
  );

endmodule

/* src/mol_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Uses no package items.
module mol_ram #(
  parameter int AW = 6,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/mol_ctrl.sv */
// Command sequencer: init, inherit search, list copy, two-pass stable reorder, reads.
// Holds inherited flags and per-stage "still the priority table" bits; uses mol_pkg.
module mol_ctrl #(
  parameter int LIST_LEN   = 60,
  parameter int NUM_STAGES = 64,
  parameter int SW         = 6,
  parameter int AW         = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [5:0]                  in_stage,
  input  logic [63:0]                 in_my_discs,
  input  logic [63:0]                 in_opp_discs,
  input  logic [mol_pkg::IDX_W-1:0]   in_entry_index,
  output logic                        out_valid,
  output logic [mol_pkg::SQ_W-1:0]    out_square_out,
  output logic                        out_copied,
  input  logic                        cfg_we,
  input  logic [mol_pkg::KEEP_W-1:0]  cfg_keep_count,
  output logic                        m_we,
  output logic [AW-1:0]               m_waddr,
  output logic [mol_pkg::SQ_W-1:0]    m_wdata,
  output logic [AW-1:0]               m_raddr,
  input  logic [mol_pkg::SQ_W-1:0]    m_rdata,
  output logic                        s_we,
  output logic [mol_pkg::IDX_W-1:0]   s_waddr,
  output logic [mol_pkg::SQ_W-1:0]    s_wdata,
  output logic [mol_pkg::IDX_W-1:0]   s_raddr,
  input  logic [mol_pkg::SQ_W-1:0]    s_rdata
);
  import mol_pkg::*;

  localparam logic [6:0] LEN      = 7'(LIST_LEN);
  localparam logic [6:0] LEN_LAST = 7'(LIST_LEN - 1);
  localparam logic [6:0] STAGES   = 7'(NUM_STAGES);

  mol_state_t          state_r, state_nxt;
  logic [NUM_STAGES-1:0] flags_r, flags_nxt;
  logic [NUM_STAGES-1:0] dflt_r, dflt_nxt;
  logic [KEEP_W-1:0]   keep_r, keep_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SQ_W-1:0]     out_sq_r, out_sq_nxt;
  logic                out_cp_r, out_cp_nxt;

  logic [5:0]          st_r, st_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [63:0]         occ_r, occ_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic                pv_r, pv_nxt;
  logic [6:0]          pi_r, pi_nxt;
  logic [6:0]          nf_r, nf_nxt;
  logic [6:0]          nb_r, nb_nxt;
  logic [5:0]          cand_r, cand_nxt;
  logic [5:0]          src_r, src_nxt;
  logic                sdflt_r, sdflt_nxt;

  logic [SW-1:0]       st_idx, in_idx, cand_idx, src_idx;
  logic                in_ok;

  assign st_idx   = st_r[SW-1:0];
  assign in_idx   = in_stage[SW-1:0];
  assign cand_idx = cand_r[SW-1:0];
  assign src_idx  = src_r[SW-1:0];
  assign in_ok    = ({1'b0, in_stage} < STAGES);

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_square_out = out_sq_r;
  assign out_copied     = out_cp_r;

  always_comb begin
    logic [SQ_W-1:0] d;
    logic            front;
    logic            issue;
    logic [6:0]      wpos;
    state_nxt     = state_r;
    flags_nxt     = flags_r;
    dflt_nxt      = dflt_r;
    keep_nxt      = cfg_we ? cfg_keep_count : keep_r;
    out_valid_nxt = 1'b0;
    out_sq_nxt    = out_sq_r;
    out_cp_nxt    = out_cp_r;
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pi_nxt        = pi_r;
    nf_nxt        = nf_r;
    nb_nxt        = nb_r;
    cand_nxt      = cand_r;
    src_nxt       = src_r;
    sdflt_nxt     = sdflt_r;
    m_we          = 1'b0;
    m_waddr       = {st_idx, pi_r[5:0]};
    m_wdata       = m_rdata;
    m_raddr       = {st_idx, cnt_r[5:0]};
    s_we          = 1'b0;
    s_waddr       = nb_r[5:0];
    s_wdata       = m_rdata;
    s_raddr       = cnt_r[5:0];

    // a stage still at its init value reads straight from the priority table
    d     = sdflt_r ? prio_sq(pi_r[5:0]) : m_rdata;
    front = (pi_r < keep_r) || !occ_r[d];
    issue = 1'b0;
    wpos  = 7'(nf_r + pi_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt     = in_stage;
          idx_nxt    = in_entry_index;
          occ_nxt    = in_my_discs | in_opp_discs;
          cnt_nxt    = '0;
          nf_nxt     = '0;
          nb_nxt     = '0;
          out_sq_nxt = '0;
          out_cp_nxt = 1'b0;
          unique case (in_mode)
            MODE_INIT: begin
              dflt_nxt      = '1;
              flags_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            MODE_INHERIT: begin
              if (!in_ok || flags_r[in_idx]) begin
                out_valid_nxt = 1'b1;
              end else begin
                flags_nxt[in_idx] = 1'b1;
                if (in_stage < PARITY_STEP) begin
                  out_valid_nxt = 1'b1;
                end else begin
                  cand_nxt  = in_stage - PARITY_STEP;
                  state_nxt = S_SEARCH;
                end
              end
            end
            MODE_REORDER: begin
              if (!in_ok) begin
                out_valid_nxt = 1'b1;
              end else begin
                sdflt_nxt        = dflt_r[in_idx];
                dflt_nxt[in_idx] = 1'b0;
                state_nxt        = S_SORT;
              end
            end
            MODE_READ: begin
              if (!in_ok || ({1'b0, in_entry_index} >= LEN)) begin
                out_valid_nxt = 1'b1;
              end else if (dflt_r[in_idx]) begin
                out_sq_nxt    = prio_sq(in_entry_index);
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // walk back two stages a cycle to the nearest marked one
      S_SEARCH: begin
        if (flags_r[cand_idx]) begin
          if (dflt_r[cand_idx]) begin
            dflt_nxt[st_idx] = 1'b1;
            out_cp_nxt       = 1'b1;
            out_valid_nxt    = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            dflt_nxt[st_idx] = 1'b0;
            src_nxt          = cand_r;
            cnt_nxt          = '0;
            state_nxt        = S_COPY;
          end
        end else if (cand_r < PARITY_STEP) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cand_nxt = cand_r - PARITY_STEP;
        end
      end

      S_COPY: begin
        m_raddr = {src_idx, cnt_r[5:0]};
        issue   = (cnt_r < LEN);
        if (issue) begin
          cnt_nxt = cnt_r + 7'd1;
          pi_nxt  = cnt_r;
        end
        pv_nxt = issue;
        if (pv_r) begin
          m_we = 1'b1;
          if (pi_r == LEN_LAST) begin
            out_cp_nxt    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      // pass one: front words compact in place, back words park in scratch
      S_SORT: begin
        issue = (cnt_r < LEN);
        if (issue) begin
          cnt_nxt = cnt_r + 7'd1;
          pi_nxt  = cnt_r;
        end
        pv_nxt = issue;
        if (pv_r) begin
          if (front) begin
            m_we    = 1'b1;
            m_waddr = {st_idx, nf_r[5:0]};
            m_wdata = d;
            nf_nxt  = nf_r + 7'd1;
          end else begin
            s_we    = 1'b1;
            s_wdata = d;
            nb_nxt  = nb_r + 7'd1;
          end
          if (pi_r == LEN_LAST) begin
            cnt_nxt = '0;
            if (nb_nxt == 7'd0) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_DRAIN;
            end
          end
        end
      end

      // pass two: scratch words go behind the front ones
      S_DRAIN: begin
        issue = (cnt_r < nb_r);
        if (issue) begin
          cnt_nxt = cnt_r + 7'd1;
          pi_nxt  = cnt_r;
        end
        pv_nxt = issue;
        if (pv_r) begin
          m_we    = 1'b1;
          m_waddr = {st_idx, wpos[5:0]};
          m_wdata = s_rdata;
          if (7'(pi_r + 7'd1) == nb_r) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      S_READ: begin
        m_raddr   = {st_idx, idx_r};
        state_nxt = S_RDATA;
      end

      S_RDATA: begin
        out_sq_nxt    = m_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      dflt_r      <= '0;
      keep_r      <= KEEP_RESET;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      dflt_r      <= dflt_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sq_r <= out_sq_nxt;
    out_cp_r <= out_cp_nxt;
    st_r     <= st_nxt;
    idx_r    <= idx_nxt;
    occ_r    <= occ_nxt;
    cnt_r    <= cnt_nxt;
    pi_r     <= pi_nxt;
    nf_r     <= nf_nxt;
    nb_r     <= nb_nxt;
    cand_r   <= cand_nxt;
    src_r    <= src_nxt;
    sdflt_r  <= sdflt_nxt;
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for move_order_list_table: directed and random commands,
// keep_count writes between phases, results checked against an in-bench list model.
// Depends on mol_pkg and the block's RTL in src.
module testbench;
  import mol_pkg::*;

  localparam int LIST_LEN   = 60;
  localparam int NUM_STAGES = 64;

  typedef struct packed {
    bit              is_cfg;
    bit [KEEP_W-1:0] keep;
    bit [4:0]        gap;
    bit [1:0]        mode;
    bit [5:0]        stage;
    bit [63:0]       my_discs;
    bit [63:0]       opp_discs;
    bit [IDX_W-1:0]  entry_index;
  } drive_op_t;

  typedef struct packed {
    bit [SQ_W-1:0] square;
    bit            copied;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = MODE_INIT;
  logic [5:0]         in_stage = '0;
  logic [63:0]        in_my_discs = '0;
  logic [63:0]        in_opp_discs = '0;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic               out_valid;
  logic [SQ_W-1:0]    out_square_out;
  logic               out_copied;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [KEEP_W-1:0]  cfg_keep_count = KEEP_RESET;

  move_order_list_table #(
    .LIST_LEN  (LIST_LEN),
    .NUM_STAGES(NUM_STAGES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_stage      (in_stage),
    .in_my_discs   (in_my_discs),
    .in_opp_discs  (in_opp_discs),
    .in_entry_index(in_entry_index),
    .out_valid     (out_valid),
    .out_square_out(out_square_out),
    .out_copied    (out_copied),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_keep_count(cfg_keep_count)
  );

  always #6 clk = ~clk;

  // list model
  bit [5:0] prio_order [64] = '{
    0, 63, 56, 7,
    2, 5, 16, 23, 40, 47, 58, 61,
    18, 21, 42, 45,
    3, 4, 24, 31, 32, 39, 59, 60,
    19, 20, 26, 29, 34, 37, 43, 44,
    11, 12, 25, 30, 33, 38, 51, 52,
    10, 13, 17, 22, 41, 46, 50, 53,
    1, 6, 8, 15, 48, 55, 57, 62,
    9, 14, 49, 54,
    27, 28, 35, 36
  };
  bit [SQ_W-1:0]   stage_lists [NUM_STAGES][LIST_LEN];
  bit [63:0]       marked_stages;
  bit [KEEP_W-1:0] held_keep = KEEP_RESET;

  drive_op_t    op_q [$];
  list_result_t pending_results [$];
  drive_op_t    cur;
  bit           holding;
  int           gap_left;
  int           issued;
  int           results_seen;
  int           queued_cmds;
  int           idle_pct;
  int           errors;

  function automatic list_result_t apply_command(input logic [1:0] mode,
                                                 input logic [5:0] stage,
                                                 input logic [63:0] occupied,
                                                 input logic [IDX_W-1:0] idx);
    list_result_t  r;
    bit [SQ_W-1:0] front [LIST_LEN];
    bit [SQ_W-1:0] back [LIST_LEN];
    bit [SQ_W-1:0] sq;
    int            nf, nb, src, i, s;
    r = '0;
    nf = 0;
    nb = 0;
    if (mode == MODE_INIT) begin
      for (s = 0; s < NUM_STAGES; s++)
        for (i = 0; i < LIST_LEN; i++) stage_lists[s][i] = prio_order[i];
      marked_stages = '0;
    end else if (int'(stage) < NUM_STAGES) begin
      case (mode)
        MODE_INHERIT: begin
          if (!marked_stages[stage]) begin
            marked_stages[stage] = 1'b1;
            // nearest earlier marked stage of the same parity; none for stages zero and one
            src = int'(stage) - 2;
            while (src >= 0 && !marked_stages[src]) src -= 2;
            if (src >= 0) begin
              for (i = 0; i < LIST_LEN; i++) stage_lists[stage][i] = stage_lists[src][i];
              r.copied = 1'b1;
            end
          end
        end
        MODE_REORDER: begin
          // stable partition: kept prefix and empty squares first
          for (i = 0; i < LIST_LEN; i++) begin
            sq = stage_lists[stage][i];
            if (i < held_keep || !occupied[sq]) begin
              front[nf] = sq;
              nf++;
            end else begin
              back[nb] = sq;
              nb++;
            end
          end
          for (i = 0; i < nf; i++) stage_lists[stage][i] = front[i];
          for (i = 0; i < nb; i++) stage_lists[stage][nf + i] = back[i];
        end
        MODE_READ: begin
          if (int'(idx) < LIST_LEN) r.square = stage_lists[stage][idx];
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [6:0] want,
                                 input logic [6:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic push_cmd(input logic [1:0] mode, input logic [5:0] stage,
                          input logic [63:0] mine, input logic [63:0] theirs,
                          input logic [IDX_W-1:0] idx);
    drive_op_t op;
    op = '0;
    op.mode = mode;
    op.stage = stage;
    op.my_discs = mine;
    op.opp_discs = theirs;
    op.entry_index = idx;
    op.gap = ($urandom_range(99) < idle_pct) ? 5'($urandom_range(17, 1)) : 5'd0;
    op_q.push_back(op);
    queued_cmds++;
  endtask

  task automatic push_keep(input logic [KEEP_W-1:0] value);
    drive_op_t op;
    op = '0;
    op.is_cfg = 1'b1;
    op.keep = value;
    op_q.push_back(op);
  endtask

  // driver: one op held at a time; keep_count words wait until all results are in
  always @(posedge clk) begin
    if (!rst_n) begin
      holding = 1'b0;
      gap_left = 0;
      issued = 0;
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (holding) begin
        if (cur.is_cfg) begin
          if (cfg_valid && cfg_ready) holding = 1'b0;
        end else if (start && !busy) begin
          holding = 1'b0;
          issued++;
        end else if (gap_left > 0) begin
          gap_left--;
        end
      end
      if (!holding && op_q.size() > 0 && (!op_q[0].is_cfg || results_seen >= issued)) begin
        cur = op_q.pop_front();
        holding = 1'b1;
        gap_left = cur.gap;
      end
      start <= holding && !cur.is_cfg && gap_left == 0;
      cfg_valid <= holding && cur.is_cfg;
      cfg_keep_count <= cur.keep;
      in_mode <= cur.mode;
      in_stage <= cur.stage;
      in_my_discs <= cur.my_discs;
      in_opp_discs <= cur.opp_discs;
      in_entry_index <= cur.entry_index;
    end
  end

  // monitor: check result words, then predict for the command word taken at this edge
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, square", 7'h7f, 7'(out_square_out));
        end else begin
          want = pending_results.pop_front();
          if (out_square_out !== want.square)
            report_mismatch("square_out", 7'(want.square), 7'(out_square_out));
          if (out_copied !== want.copied)
            report_mismatch("copied", 7'(want.copied), 7'(out_copied));
        end
      end
      if (cfg_valid && cfg_ready) held_keep = cfg_keep_count;
      if (start && !busy)
        pending_results.push_back(apply_command(in_mode, in_stage,
                                                in_my_discs | in_opp_discs, in_entry_index));
    end
  end

  initial begin
    logic [63:0] mine, theirs;
    logic [5:0]  focus, st;
    logic [1:0]  md;
    int          pick, reps, target, ph;
    int          phase_keep [6];
    int          phase_idle [6];

    idle_pct = 25;
    // directed: runs at the reset keep count of 24 until the first write
    push_cmd(MODE_INHERIT, 6'd1, '0, '0, 6'd0);   // before any init: only marks
    push_cmd(MODE_INIT, 6'd63, '1, '1, 6'd63);
    push_cmd(MODE_READ, 6'd0, '0, '0, 6'd0);
    push_cmd(MODE_READ, 6'd63, '0, '0, 6'd59);
    push_cmd(MODE_READ, 6'd31, '0, '0, 6'd60);    // index past the list
    push_cmd(MODE_READ, 6'd31, '0, '0, 6'd63);
    push_cmd(MODE_INHERIT, 6'd0, '0, '0, 6'd0);   // stage zero never copies
    push_cmd(MODE_INHERIT, 6'd0, '0, '0, 6'd0);   // already marked
    push_cmd(MODE_REORDER, 6'd0, 64'hFFFF_0000_0000_FFFF, 64'h0000_00FF_FF00_0000, 6'd0);
    push_cmd(MODE_INHERIT, 6'd4, '0, '0, 6'd0);   // copies reordered stage 0
    push_cmd(MODE_READ, 6'd4, '0, '0, 6'd40);
    push_cmd(MODE_INHERIT, 6'd2, '0, '0, 6'd0);
    push_cmd(MODE_INHERIT, 6'd3, '0, '0, 6'd0);   // no odd stage marked yet
    push_cmd(MODE_INHERIT, 6'd63, '0, '0, 6'd0);  // walks down to stage 3
    push_cmd(MODE_REORDER, 6'd5, '0, '0, 6'd0);   // all squares empty
    push_cmd(MODE_REORDER, 6'd5, '1, '0, 6'd0);   // all occupied
    push_cmd(MODE_REORDER, 6'd6, '0, '1, 6'd0);
    push_cmd(MODE_READ, 6'd5, '0, '0, 6'd30);
    push_cmd(MODE_REORDER, 6'd7, 64'h8100_0000_0000_0081, 64'h0000_0018_1800_0000, 6'd0);
    push_cmd(MODE_READ, 6'd7, '0, '0, 6'd24);
    push_cmd(MODE_READ, 6'd7, '0, '0, 6'd59);
    push_keep(7'd64);                             // keep count beyond the list
    push_cmd(MODE_REORDER, 6'd8, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0505_0505_0505_0505, 6'd0);
    push_cmd(MODE_READ, 6'd8, '0, '0, 6'd30);
    push_keep(7'd0);
    push_cmd(MODE_REORDER, 6'd9, 64'h00FF_00FF_00FF_00FF, '0, 6'd0);
    push_cmd(MODE_READ, 6'd9, '0, '0, 6'd0);
    push_cmd(MODE_READ, 6'd9, '0, '0, 6'd59);

    phase_keep = '{60, 0, 59, 64, int'($urandom_range(58, 1)), int'($urandom_range(64))};
    phase_idle = '{30, 0, 60, 15, 45, 0};
    focus = 6'($urandom_range(63));
    for (ph = 0; ph < 6; ph++) begin
      push_keep(7'(phase_keep[ph]));
      idle_pct = phase_idle[ph];
      target = queued_cmds + 313;
      while (queued_cmds < target) begin
        if ($urandom_range(39) == 0) focus = 6'($urandom_range(63));
        // mostly a cluster of nearby stages so inherit finds marked stages
        st = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : focus + 6'($urandom_range(7));
        case ($urandom_range(3))
          0: begin
            mine = {$urandom, $urandom};
            theirs = {$urandom, $urandom} & ~mine;
          end
          1: begin
            mine = {$urandom, $urandom} & {$urandom, $urandom};
            theirs = {$urandom, $urandom} & {$urandom, $urandom} & ~mine;
          end
          2: begin
            mine = {$urandom, $urandom};
            theirs = {$urandom, $urandom};
          end
          default: begin
            mine = $urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
            theirs = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          end
        endcase
        pick = $urandom_range(99);
        md = (pick < 3) ? MODE_INIT : (pick < 25) ? MODE_INHERIT :
             (pick < 50) ? MODE_REORDER : MODE_READ;
        push_cmd(md, st, mine, theirs, 6'($urandom_range(63)));
        if (md == MODE_INHERIT || md == MODE_REORDER) begin
          reps = $urandom_range(3);
          repeat (reps) push_cmd(MODE_READ, st, mine, theirs, 6'($urandom_range(63)));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (op_q.size() != 0 || holding || results_seen < issued);
    repeat (200) @(negedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("%0t: timeout, %0d commands issued, %0d results seen", $time, issued,
             results_seen);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
